### rtl/free_list_page_allocator_unit_macros.svh
// Assertion macros for the free-list page allocator.
`ifndef FREE_LIST_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_LIST_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTH
// Check prop on the given clock, skipped while the given active-low reset is low.
`define FLPA_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("flpa assertion failed");
// Check prop on clk_i, skipped during rst_ni.
`define FLPA_ASSERT(lbl, prop) `FLPA_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define FLPA_ASSERT_CLK(lbl, clk, rst_n, prop)
`define FLPA_ASSERT(lbl, prop)
`endif
`endif

### rtl/flpa_pkg.sv
// Shared types and constants of the free-list page allocator.
package flpa_pkg;

  localparam int unsigned PAGE_W     = 12;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned RSV_W      = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h4000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 3'd0,
    CMD_ALLOC = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_P2A   = 3'd3,
    CMD_A2P   = 3'd4
  } flpa_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE = 1'b0,
    CFG_RESERVED    = 1'b1
  } flpa_cfg_e;

  // controller to datapath
  typedef struct packed {
    logic ready;       // input side may take an item
    logic take;        // item accepted this cycle
    logic imm_load;    // immediate command: load its result
    logic init_step;   // write one link of the init sweep
    logic init_load;   // load the empty init result
    logic alloc_load;  // pop the head and load the alloc result
  } flpa_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register empty or drained this cycle
    logic sweep_last;  // init sweep at its last page
  } flpa_sts_t;

endpackage

### rtl/flpa_ctrl.sv
// Command sequencer of the free-list page allocator.
module flpa_ctrl
  import flpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  flpa_sts_t        sts_i,
  output flpa_ctl_t        ctl_o
);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_ALLOC    = 4'b0010,
    ST_INIT     = 4'b0100,
    ST_INIT_END = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        ctl_o.ready = sts_i.out_free;
        ctl_o.take  = sts_i.out_free & s_valid_i;
        if (ctl_o.take) begin
          if (cmd_i == CMD_INIT) begin
            state_d = ST_INIT;
          end else if (cmd_i == CMD_ALLOC) begin
            state_d = ST_ALLOC;
          end else begin
            ctl_o.imm_load = 1'b1;
          end
        end
      end
      ST_ALLOC: begin
        // link read is registered; hold it until the output can take the item
        if (sts_i.out_free) begin
          ctl_o.alloc_load = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_INIT: begin
        ctl_o.init_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_INIT_END;
        end
      end
      ST_INIT_END: begin
        if (sts_i.out_free) begin
          ctl_o.init_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/flpa_datapath.sv
// Link memory, head register, address conversion and output register.
module flpa_datapath
  import flpa_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 4096,
  parameter int unsigned PAGE_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [PAGE_W-1:0]    page_index_i,
  input  logic                 page_present_i,
  input  logic [ADDR_W-1:0]    phys_addr_i,
  input  flpa_ctl_t            ctl_i,
  output flpa_sts_t            sts_o,
  input  logic                 m_ready_i,
  output logic                 m_valid_o,
  output logic [PAGE_W-1:0]    out_page_o,
  output logic                 out_valid_o,
  output logic [ADDR_W-1:0]    out_addr_o
);

  localparam int unsigned IDX_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_PAGES + 1);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam logic [31:0] NUM_PAGES_W = 32'(NUM_PAGES);
  localparam logic [IDX_W-1:0] LAST_PAGE = IDX_W'(NUM_PAGES - 1);

  // configuration
  logic [ADDR_W-1:0] base_q;
  logic [RSV_W-1:0]  rsv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      rsv_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REGION_BASE: base_q <= cfg_wdata_i;
        CFG_RESERVED:    rsv_q  <= cfg_wdata_i[RSV_W-1:0];
        default:         ;
      endcase
    end
  end

  // free list state
  logic [IDX_W-1:0]  head_q;
  logic              head_valid_q;
  logic [IDX_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  first_q;
  logic [CNT_W-1:0]  first_c;
  logic              init_nonempty;
  logic [LINK_W-1:0] mem [NUM_PAGES];
  logic [LINK_W-1:0] rd_q;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_addr;
  logic [LINK_W-1:0] mem_wdata;
  logic [31:0]       page_ext;
  logic [IDX_W-1:0]  page_addr;
  logic              page_ok;
  logic              free_do;
  logic              take_init;
  logic              take_alloc;
  logic              sweep_link_vld;
  logic [IDX_W-1:0]  sweep_link_page;

  assign page_ext  = 32'(page_index_i);
  assign page_addr = page_ext[IDX_W-1:0];
  assign page_ok   = page_present_i && (page_ext < NUM_PAGES_W);

  assign take_init  = ctl_i.take && (cmd_i == CMD_INIT);
  assign take_alloc = ctl_i.take && (cmd_i == CMD_ALLOC);
  assign free_do    = ctl_i.take && (cmd_i == CMD_FREE) && page_ok;

  // clamp reserved count to the page count
  assign first_c       = (32'(rsv_q) >= NUM_PAGES_W) ? CNT_W'(NUM_PAGES) : CNT_W'(rsv_q);
  assign init_nonempty = first_c < CNT_W'(NUM_PAGES);

  // each free page above the first links to the page below it
  assign sweep_link_vld  = CNT_W'(cnt_q) > first_q;
  assign sweep_link_page = sweep_link_vld ? (cnt_q - IDX_W'(1)) : '0;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = head_q;
    mem_wdata = '0;
    if (ctl_i.init_step) begin
      mem_we    = 1'b1;
      mem_addr  = cnt_q;
      mem_wdata = {sweep_link_vld, sweep_link_page};
    end else if (free_do) begin
      mem_we    = 1'b1;
      mem_addr  = page_addr;
      mem_wdata = {head_valid_q, head_q};
    end else if (ctl_i.alloc_load) begin
      // clear the link of the popped page
      mem_we    = head_valid_q;
      mem_addr  = head_q;
    end else if (take_alloc) begin
      mem_re    = 1'b1;
      mem_addr  = head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      head_valid_q <= 1'b0;
      cnt_q        <= '0;
      first_q      <= '0;
    end else begin
      if (take_init) begin
        head_valid_q <= init_nonempty;
        head_q       <= init_nonempty ? LAST_PAGE : '0;
        cnt_q        <= '0;
        first_q      <= first_c;
      end else if (free_do) begin
        head_q       <= page_addr;
        head_valid_q <= 1'b1;
      end else if (ctl_i.alloc_load && head_valid_q) begin
        head_q       <= rd_q[IDX_W-1:0];
        head_valid_q <= rd_q[IDX_W];
      end
      if (ctl_i.init_step) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
    end
  end

  // immediate results
  logic [PAGE_W-1:0] imm_page;
  logic              imm_valid;
  logic [ADDR_W-1:0] imm_addr;
  logic [ADDR_W-1:0] a2p_off;
  logic [ADDR_W-1:0] a2p_idx;
  logic [31:0]       head_ext;

  assign a2p_off  = phys_addr_i - base_q;
  assign a2p_idx  = a2p_off >> PAGE_BITS;
  assign head_ext = 32'(head_q);

  always_comb begin
    imm_page  = '0;
    imm_valid = 1'b0;
    imm_addr  = '0;
    case (cmd_i)
      CMD_P2A: begin
        if (page_ok) begin
          imm_page  = page_index_i;
          imm_valid = 1'b1;
          imm_addr  = base_q + (page_ext << PAGE_BITS);
        end
      end
      CMD_A2P: begin
        if ((phys_addr_i >= base_q) && (a2p_idx < NUM_PAGES_W)) begin
          imm_page  = a2p_idx[PAGE_W-1:0];
          imm_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  logic              m_valid_q;
  logic [PAGE_W-1:0] out_page_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_load;

  assign out_load = ctl_i.imm_load | ctl_i.alloc_load | ctl_i.init_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.imm_load) begin
      out_page_q  <= imm_page;
      out_valid_q <= imm_valid;
      out_addr_q  <= imm_addr;
    end else if (ctl_i.alloc_load) begin
      out_page_q  <= head_valid_q ? head_ext[PAGE_W-1:0] : '0;
      out_valid_q <= head_valid_q;
      out_addr_q  <= '0;
    end else if (ctl_i.init_load) begin
      out_page_q  <= '0;
      out_valid_q <= 1'b0;
      out_addr_q  <= '0;
    end
  end

  assign sts_o.out_free   = !m_valid_q || m_ready_i;
  assign sts_o.sweep_last = cnt_q == LAST_PAGE;

  assign m_valid_o   = m_valid_q;
  assign out_page_o  = out_page_q;
  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_addr_q;

endmodule

### rtl/free_list_page_allocator_unit.sv
// Free-list page allocator: one item in, one result item out, one item at a time.
// Free, page-to-address, address-to-page and unused codes load their result when
// taken; alloc reads the head's link from the single-port link memory, then,
// once the output is free, replaces the head and clears the popped link; init
// sweeps one link per cycle through that same port, then loads its empty result.
// While idle, a new item is taken as soon as the output register is empty or
// drained in that cycle. The link memory is not cleared at reset: run init
// before the first alloc. The user writes configuration (index 0 region base,
// index 1 reserved pages) via cfg_we_i while idle; the block does not enforce it.
`include "free_list_page_allocator_unit_macros.svh"

module free_list_page_allocator_unit
  import flpa_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 4096,
  parameter int unsigned PAGE_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ADDR_W-1:0]     cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // page_index [11:0], page_present [12], phys_addr [44:13], zero [47:45]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd [2:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_page [11:0], out_valid [12], out_addr [44:13], zero [47:45]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  flpa_ctl_t         ctl_s;
  flpa_sts_t         sts_s;
  logic [PAGE_W-1:0] out_page_s;
  logic              out_valid_s;
  logic [ADDR_W-1:0] out_addr_s;

  flpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .cmd_i     (s_axis_tuser),
    .sts_i     (sts_s),
    .ctl_o     (ctl_s)
  );

  flpa_datapath #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (s_axis_tuser),
    .page_index_i   (s_axis_tdata[11:0]),
    .page_present_i (s_axis_tdata[12]),
    .phys_addr_i    (s_axis_tdata[44:13]),
    .ctl_i          (ctl_s),
    .sts_o          (sts_s),
    .m_ready_i      (m_axis_tready),
    .m_valid_o      (m_axis_tvalid),
    .out_page_o     (out_page_s),
    .out_valid_o    (out_valid_s),
    .out_addr_o     (out_addr_s)
  );

  assign s_axis_tready = ctl_s.ready;
  assign m_axis_tdata  = {3'b000, out_addr_s, out_valid_s, out_page_s};

  `FLPA_ASSERT(a_ready_only_idle, s_axis_tready |-> !ctl_s.alloc_load && !ctl_s.init_step && !ctl_s.init_load)
  `FLPA_ASSERT(a_take_is_handshake, ctl_s.take == (s_axis_tvalid && s_axis_tready))
  `FLPA_ASSERT(a_init_blocks_input, (ctl_s.take && s_axis_tuser == CMD_INIT) |=> !s_axis_tready)
  `FLPA_ASSERT_CLK(a_alloc_out_free, clk_i, rst_ni, ctl_s.alloc_load |-> sts_s.out_free)

endmodule
